[rtl/laguerre_series_clenshaw_eval_defines.svh]
// ----------------------------------------------------------------------------
// Laguerre series evaluator assertion macros
// Shared concurrent assertion forms for the port checker. The clock is named
// clock and the reset is named reset in every scope that uses them.
// ----------------------------------------------------------------------------
`ifndef LAGUERRE_SERIES_CLENSHAW_EVAL_DEFINES_SVH
`define LAGUERRE_SERIES_CLENSHAW_EVAL_DEFINES_SVH

// Check a property on every clock edge outside reset
`define LSC_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included
`define LSC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/lsc_pkg.sv]
// ----------------------------------------------------------------------------
// Laguerre series evaluator package
// Widths, codes, state types and saturating helpers shared by the datapath.
// ----------------------------------------------------------------------------
package lsc_pkg;

   localparam int WORD_W     = 64;
   localparam int DEG_W      = 8;
   localparam int DEG_MAX    = (1 << DEG_W) - 1;
   localparam int DIVISOR_W  = DEG_W + 1;
   localparam int DIGIT_W    = 2;
   localparam int STEP_COUNT = WORD_W / DIGIT_W;
   localparam int STEP_W     = $clog2(STEP_COUNT);
   localparam int CSR_IDX_W  = 2;

   localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EVAL_POINT    = 2'd0,
      CSR_ALPHA_PARAM   = 2'd1,
      CSR_SERIES_DEGREE = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP1,
      ST_PREP2,
      ST_LAUNCH,
      ST_CALC,
      ST_NEG,
      ST_SUB,
      ST_SUM
   } step_state_type;

   typedef enum logic [2:0] {
      MUL_IDLE,
      MUL_MAG,
      MUL_TRIPLE,
      MUL_RUN,
      MUL_FIN
   } mul_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_ADD,
      DIV_RUN,
      DIV_FIN
   } div_state_type;

   typedef struct packed {
      logic              sat;
      logic [WORD_W-1:0] value;
   } sat_word_type;

   typedef struct packed {
      logic              neg;
      logic              sat;
      logic [WORD_W-1:0] mag;
   } mul_result_type;

   // Two's complement add, clamped on overflow
   function automatic sat_word_type sat_add(input logic [WORD_W-1:0] a,
                                            input logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] sum;
      sat_word_type      res;
      sum       = a + b;
      res.sat   = (a[WORD_W-1] == b[WORD_W-1]) && (sum[WORD_W-1] != a[WORD_W-1]);
      res.value = res.sat ? (a[WORD_W-1] ? WORD_MIN : WORD_MAX) : sum;
      return res;
   endfunction

   // Two's complement subtract, clamped on overflow
   function automatic sat_word_type sat_sub(input logic [WORD_W-1:0] a,
                                            input logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] diff;
      sat_word_type      res;
      diff      = a - b;
      res.sat   = (a[WORD_W-1] != b[WORD_W-1]) && (diff[WORD_W-1] != a[WORD_W-1]);
      res.value = res.sat ? (a[WORD_W-1] ? WORD_MIN : WORD_MAX) : diff;
      return res;
   endfunction

endpackage

[rtl/lsc_serial_mul.sv]
// ----------------------------------------------------------------------------
// Serial fixed-point multiplier
// Radix-4 shift-add multiply of two signed words in sign-magnitude form. The
// rounding bias rides in the accumulator from the start; the last cycle
// drops the fraction bits and clamps the magnitude to the signed range.
// ----------------------------------------------------------------------------
module lsc_serial_mul #(
   parameter int FRAC_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lsc_pkg::WORD_W-1:0]   op_a,
   input  logic [lsc_pkg::WORD_W-1:0]   op_b,
   output logic                         done,
   output lsc_pkg::mul_result_type      result
);

   localparam int W      = lsc_pkg::WORD_W;
   localparam int DW     = lsc_pkg::DIGIT_W;
   localparam int SW     = lsc_pkg::STEP_W;
   localparam int HI_W   = W + DW;
   localparam int ACC_W  = W + HI_W;
   localparam int UP_W   = ACC_W - W - FRAC_BITS;
   localparam logic [HI_W-1:0] HALF_LSB = HI_W'(1) << (FRAC_BITS - 1);
   localparam logic [SW-1:0]   LAST_STEP = SW'(lsc_pkg::STEP_COUNT - 1);

   lsc_pkg::mul_state_type  state_ff, state_in;
   logic [W-1:0]            a_ff, a_in;
   logic [W-1:0]            b_ff, b_in;
   logic                    neg_ff, neg_in;
   logic [HI_W-1:0]         triple_ff, triple_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [SW-1:0]           step_ff, step_in;
   lsc_pkg::mul_result_type res_ff, res_in;
   logic                    done_ff, done_in;

   logic [HI_W-1:0] partial;
   logic [HI_W-1:0] hi_sum;
   logic [W-1:0]    rm;
   logic            up_any;
   logic            over;

   // Sequence the phases of one product
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsc_pkg::MUL_IDLE:   if (start) state_in = lsc_pkg::MUL_MAG;
         lsc_pkg::MUL_MAG:    state_in = lsc_pkg::MUL_TRIPLE;
         lsc_pkg::MUL_TRIPLE: state_in = lsc_pkg::MUL_RUN;
         lsc_pkg::MUL_RUN:    if (step_ff == '0) state_in = lsc_pkg::MUL_FIN;
         lsc_pkg::MUL_FIN:    state_in = lsc_pkg::MUL_IDLE;
         default:             state_in = lsc_pkg::MUL_IDLE;
      endcase
   end

   // Flag the result in the cycle after the final phase
   always_comb begin
      done_in = (state_ff == lsc_pkg::MUL_FIN);
   end

   // Select the partial product for the current multiplier digit
   always_comb begin
      unique case (acc_ff[DW-1:0])
         2'd0:    partial = '0;
         2'd1:    partial = {{DW{1'b0}}, a_ff};
         2'd2:    partial = {1'b0, a_ff, 1'b0};
         2'd3:    partial = triple_ff;
         default: partial = '0;
      endcase
      hi_sum = acc_ff[ACC_W-1 -: HI_W] + partial;
   end

   // Round, drop the fraction and clamp
   always_comb begin
      rm     = acc_ff[FRAC_BITS +: W];
      up_any = |acc_ff[ACC_W-1 -: UP_W];
      if (neg_ff) begin
         over = up_any | (rm[W-1] & (|rm[W-2:0]));
      end else begin
         over = up_any | rm[W-1];
      end
   end

   // Advance the datapath
   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      neg_in    = neg_ff;
      triple_in = triple_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      res_in    = res_ff;
      unique case (state_ff)
         lsc_pkg::MUL_IDLE: begin
            if (start) begin
               a_in   = op_a;
               b_in   = op_b;
               neg_in = op_a[W-1] ^ op_b[W-1];
            end
         end
         lsc_pkg::MUL_MAG: begin
            a_in = a_ff[W-1] ? (~a_ff + W'(1)) : a_ff;
            b_in = b_ff[W-1] ? (~b_ff + W'(1)) : b_ff;
         end
         lsc_pkg::MUL_TRIPLE: begin
            triple_in = {{DW{1'b0}}, a_ff} + {1'b0, a_ff, 1'b0};
            acc_in    = {HALF_LSB - HI_W'(neg_ff), b_ff};
            step_in   = LAST_STEP;
         end
         lsc_pkg::MUL_RUN: begin
            acc_in  = {{DW{1'b0}}, hi_sum, acc_ff[W-1:DW]};
            step_in = step_ff - SW'(1);
         end
         lsc_pkg::MUL_FIN: begin
            res_in.neg = neg_ff;
            res_in.sat = over;
            if (over) begin
               res_in.mag = neg_ff ? lsc_pkg::WORD_MIN : lsc_pkg::WORD_MAX;
            end else begin
               res_in.mag = rm;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsc_pkg::MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Hold operands and accumulator
   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      neg_ff    <= neg_in;
      triple_ff <= triple_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      res_ff    <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

[rtl/lsc_serial_div.sv]
// ----------------------------------------------------------------------------
// Serial rounding divider
// Divides an unsigned word by a small divisor, rounding to nearest with ties
// away from zero. Restoring radix-4 long division: two dividend bits per
// cycle against a narrow remainder.
// ----------------------------------------------------------------------------
module lsc_serial_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [lsc_pkg::WORD_W-1:0]      dividend,
   input  logic [lsc_pkg::DIVISOR_W-1:0]   divisor,
   output logic                            done,
   output logic [lsc_pkg::WORD_W-1:0]      quotient
);

   localparam int W   = lsc_pkg::WORD_W;
   localparam int DW  = lsc_pkg::DIGIT_W;
   localparam int SW  = lsc_pkg::STEP_W;
   localparam int VW  = lsc_pkg::DIVISOR_W;
   localparam int TW  = VW + DW;
   localparam logic [SW-1:0] LAST_STEP = SW'(lsc_pkg::STEP_COUNT - 1);

   lsc_pkg::div_state_type state_ff, state_in;
   logic [W-1:0]           num_ff, num_in;
   logic [VW-1:0]          dvs_ff, dvs_in;
   logic [TW-1:0]          d2_ff, d2_in;
   logic [TW-1:0]          d3_ff, d3_in;
   logic [VW-1:0]          rem_ff, rem_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [W-1:0]           quot_ff, quot_in;
   logic                   done_ff, done_in;

   logic [TW-1:0] trial;
   logic [TW-1:0] d1_ext;
   logic [TW-1:0] trial_rem;
   logic [DW-1:0] qdigit;

   // Sequence the phases of one division
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsc_pkg::DIV_IDLE: if (start) state_in = lsc_pkg::DIV_ADD;
         lsc_pkg::DIV_ADD:  state_in = lsc_pkg::DIV_RUN;
         lsc_pkg::DIV_RUN:  if (step_ff == '0) state_in = lsc_pkg::DIV_FIN;
         lsc_pkg::DIV_FIN:  state_in = lsc_pkg::DIV_IDLE;
         default:           state_in = lsc_pkg::DIV_IDLE;
      endcase
   end

   // Flag the quotient in the cycle after the final phase
   always_comb begin
      done_in = (state_ff == lsc_pkg::DIV_FIN);
   end

   // Pick the largest multiple of the divisor that fits
   always_comb begin
      trial  = {rem_ff, num_ff[W-1 -: DW]};
      d1_ext = {{DW{1'b0}}, dvs_ff};
      priority if (trial >= d3_ff) begin
         qdigit    = 2'd3;
         trial_rem = trial - d3_ff;
      end else if (trial >= d2_ff) begin
         qdigit    = 2'd2;
         trial_rem = trial - d2_ff;
      end else if (trial >= d1_ext) begin
         qdigit    = 2'd1;
         trial_rem = trial - d1_ext;
      end else begin
         qdigit    = 2'd0;
         trial_rem = trial;
      end
   end

   // Advance the datapath
   always_comb begin
      num_in  = num_ff;
      dvs_in  = dvs_ff;
      d2_in   = d2_ff;
      d3_in   = d3_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      quot_in = quot_ff;
      unique case (state_ff)
         lsc_pkg::DIV_IDLE: begin
            if (start) begin
               num_in = dividend;
               dvs_in = divisor;
            end
         end
         lsc_pkg::DIV_ADD: begin
            // add half the divisor so the truncating quotient rounds
            num_in  = num_ff + W'(dvs_ff >> 1);
            d2_in   = {1'b0, dvs_ff, 1'b0};
            d3_in   = {1'b0, dvs_ff, 1'b0} + {{DW{1'b0}}, dvs_ff};
            rem_in  = '0;
            step_in = LAST_STEP;
         end
         lsc_pkg::DIV_RUN: begin
            num_in  = {num_ff[W-DW-1:0], qdigit};
            rem_in  = trial_rem[VW-1:0];
            step_in = step_ff - SW'(1);
         end
         lsc_pkg::DIV_FIN: begin
            quot_in = num_ff;
         end
         default: begin
            quot_in = quot_ff;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsc_pkg::DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Hold dividend, remainder and quotient
   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      dvs_ff  <= dvs_in;
      d2_ff   <= d2_in;
      d3_ff   <= d3_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

[rtl/laguerre_series_clenshaw_eval.sv]
// ----------------------------------------------------------------------------
// Generalized Laguerre series evaluator
// Clenshaw backward recurrence over a stream of Q-format coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Write eval_point (index 0), alpha_param (index 1) and series_degree
//   (index 2) on the csr_ port while idle; a degree write restarts the
//   evaluation. Then send degree+1 coefficients on req_, highest index first.
//   After the coefficient for index 0 one transaction leaves on rsp_ with
//   the series value and a flag for any saturation during the evaluation.
// Sequencing:
//   Each coefficient runs to the end before the next is accepted: the prep
//   states ST_PREP1 and ST_PREP2 and a launch, a radix-4 multiply and a
//   radix-4 divide (both terms run in parallel units), then the combine
//   states ST_NEG, ST_SUB and ST_SUM. The result is registered when the
//   last coefficient commits in ST_SUM.
// Reset and stall:
//   Reset clears the configuration and recurrence state to zero, degree
//   included, and drops any pending result. A stalled result
//   holds; the next evaluation keeps running and only its final coefficient
//   waits in the combine stage until the result register is free.
// ----------------------------------------------------------------------------
module laguerre_series_clenshaw_eval #(
   parameter int MAX_DEGREE = 255,
   parameter int FRAC_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [lsc_pkg::WORD_W-1:0]   req_coefficient,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lsc_pkg::WORD_W-1:0]   rsp_series_value,
   output logic                                rsp_overflow,
   input  logic                                csr_write_en,
   input  logic [lsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lsc_pkg::WORD_W-1:0]          csr_data
);

   localparam int W  = lsc_pkg::WORD_W;
   localparam int KW = lsc_pkg::DEG_W;
   localparam int VW = lsc_pkg::DIVISOR_W;
   localparam int DEG_CAP = (MAX_DEGREE < lsc_pkg::DEG_MAX) ? MAX_DEGREE : lsc_pkg::DEG_MAX;
   localparam logic [KW-1:0] DEG_CAP_W = KW'(DEG_CAP);

   function automatic logic [KW-1:0] start_index(input logic [KW-1:0] deg);
      return (deg > DEG_CAP_W) ? DEG_CAP_W : deg;
   endfunction

   lsc_pkg::step_state_type state_ff, state_in;

   logic [W-1:0]  eval_point_ff;
   logic [W-1:0]  alpha_param_ff;
   logic [KW-1:0] series_degree_ff;
   logic [KW-1:0] index_left_ff;
   logic [W-1:0]  prev_term_ff;
   logic [W-1:0]  prev_prev_term_ff;
   logic          sat_seen_ff;

   logic [W-1:0]  coef_ff;
   logic [W-1:0]  diff_ff;
   logic [W-1:0]  akp1_ff;
   logic [W-1:0]  beta_ff;
   logic [W-1:0]  val1_ff;
   logic [W-1:0]  val2_ff;
   logic [W-1:0]  delta_ff;
   logic          step_sat_ff;

   logic          rsp_valid_ff;
   logic [W-1:0]  rsp_value_ff;
   logic          rsp_overflow_ff;

   logic          accept;
   logic          out_free;
   logic          last_index;
   logic          unit_start;
   logic          commit;
   logic          req_stall_w;

   logic [W-1:0]  kp1_term;
   logic [W-1:0]  tk1_term;
   logic [VW-1:0] div_k1;
   logic [VW-1:0] div_k2;

   lsc_pkg::sat_word_type diff_res, akp1_res, beta_res, delta_res, y_res;

   lsc_pkg::mul_result_type mul_beta_res, mul_akp1_res;
   logic                    mul_beta_done, mul_akp1_done;
   logic [W-1:0]            quot1, quot2;
   logic                    div1_done, div2_done;

   assign accept     = req_valid && !req_stall_w;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_index = (index_left_ff == '0);

   // Step through the phases of one coefficient
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsc_pkg::ST_IDLE:   if (req_valid) state_in = lsc_pkg::ST_PREP1;
         lsc_pkg::ST_PREP1:  state_in = lsc_pkg::ST_PREP2;
         lsc_pkg::ST_PREP2:  state_in = lsc_pkg::ST_LAUNCH;
         lsc_pkg::ST_LAUNCH: state_in = lsc_pkg::ST_CALC;
         lsc_pkg::ST_CALC:   if (div1_done && div2_done) state_in = lsc_pkg::ST_NEG;
         lsc_pkg::ST_NEG:    state_in = lsc_pkg::ST_SUB;
         lsc_pkg::ST_SUB:    state_in = lsc_pkg::ST_SUM;
         lsc_pkg::ST_SUM:    if (!last_index || out_free) state_in = lsc_pkg::ST_IDLE;
         default:            state_in = lsc_pkg::ST_IDLE;
      endcase
   end

   // Drive handshake and unit controls from the state
   always_comb begin
      req_stall_w = (state_ff != lsc_pkg::ST_IDLE);
      unit_start  = (state_ff == lsc_pkg::ST_LAUNCH);
      commit      = (state_ff == lsc_pkg::ST_SUM) && (!last_index || out_free);
   end

   // Form the recurrence coefficients for index k
   always_comb begin
      kp1_term  = (W'(index_left_ff) + W'(1)) << FRAC_BITS;
      tk1_term  = W'({index_left_ff, 1'b1}) << FRAC_BITS;
      div_k1    = VW'(index_left_ff) + VW'(1);
      div_k2    = VW'(index_left_ff) + VW'(2);
      diff_res  = lsc_pkg::sat_sub(alpha_param_ff, eval_point_ff);
      akp1_res  = lsc_pkg::sat_add(alpha_param_ff, kp1_term);
      beta_res  = lsc_pkg::sat_add(diff_ff, tk1_term);
      delta_res = lsc_pkg::sat_sub(val1_ff, val2_ff);
      y_res     = lsc_pkg::sat_add(delta_ff, coef_ff);
   end

   // beta * y1 and (k+1+alpha) * y2 run side by side
   lsc_serial_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_beta (
      .clock  (clock),
      .reset  (reset),
      .start  (unit_start),
      .op_a   (beta_ff),
      .op_b   (prev_term_ff),
      .done   (mul_beta_done),
      .result (mul_beta_res)
   );

   lsc_serial_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_akp1 (
      .clock  (clock),
      .reset  (reset),
      .start  (unit_start),
      .op_a   (akp1_ff),
      .op_b   (prev_prev_term_ff),
      .done   (mul_akp1_done),
      .result (mul_akp1_res)
   );

   // Divide each product magnitude by k+1 and k+2
   lsc_serial_div u_div_k1 (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_beta_done),
      .dividend (mul_beta_res.mag),
      .divisor  (div_k1),
      .done     (div1_done),
      .quotient (quot1)
   );

   lsc_serial_div u_div_k2 (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_akp1_done),
      .dividend (mul_akp1_res.mag),
      .divisor  (div_k2),
      .done     (div2_done),
      .quotient (quot2)
   );

   // Hold the state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold configuration and recurrence state
   always_ff @(posedge clock) begin
      if (reset) begin
         eval_point_ff     <= '0;
         alpha_param_ff    <= '0;
         series_degree_ff  <= '0;
         index_left_ff     <= start_index('0);
         prev_term_ff      <= '0;
         prev_prev_term_ff <= '0;
         sat_seen_ff       <= 1'b0;
      end else if (csr_write_en) begin
         unique case (lsc_pkg::csr_index_type'(csr_index))
            lsc_pkg::CSR_EVAL_POINT: begin
               eval_point_ff <= csr_data;
            end
            lsc_pkg::CSR_ALPHA_PARAM: begin
               alpha_param_ff <= csr_data;
            end
            lsc_pkg::CSR_SERIES_DEGREE: begin
               series_degree_ff  <= csr_data[KW-1:0];
               index_left_ff     <= start_index(csr_data[KW-1:0]);
               prev_term_ff      <= '0;
               prev_prev_term_ff <= '0;
               sat_seen_ff       <= 1'b0;
            end
            default: begin
               sat_seen_ff <= sat_seen_ff;
            end
         endcase
      end else if (commit) begin
         if (last_index) begin
            // restart for the next evaluation
            index_left_ff     <= start_index(series_degree_ff);
            prev_term_ff      <= '0;
            prev_prev_term_ff <= '0;
            sat_seen_ff       <= 1'b0;
         end else begin
            index_left_ff     <= index_left_ff - KW'(1);
            prev_term_ff      <= y_res.value;
            prev_prev_term_ff <= prev_term_ff;
            sat_seen_ff       <= sat_seen_ff | step_sat_ff | y_res.sat;
         end
      end
   end

   // Advance the per-coefficient datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         coef_ff <= req_coefficient;
      end
      unique case (state_ff)
         lsc_pkg::ST_PREP1: begin
            diff_ff     <= diff_res.value;
            akp1_ff     <= akp1_res.value;
            step_sat_ff <= diff_res.sat | akp1_res.sat;
         end
         lsc_pkg::ST_PREP2: begin
            beta_ff     <= beta_res.value;
            step_sat_ff <= step_sat_ff | beta_res.sat;
         end
         lsc_pkg::ST_NEG: begin
            val1_ff     <= mul_beta_res.neg ? (~quot1 + W'(1)) : quot1;
            val2_ff     <= mul_akp1_res.neg ? (~quot2 + W'(1)) : quot2;
            step_sat_ff <= step_sat_ff | mul_beta_res.sat | mul_akp1_res.sat;
         end
         lsc_pkg::ST_SUB: begin
            delta_ff    <= delta_res.value;
            step_sat_ff <= step_sat_ff | delta_res.sat;
         end
         default: begin
            step_sat_ff <= step_sat_ff;
         end
      endcase
   end

   // Load the result register, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit && last_index) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && last_index) begin
         rsp_value_ff    <= y_res.value;
         rsp_overflow_ff <= sat_seen_ff | step_sat_ff | y_res.sat;
      end
   end

   assign req_stall        = req_stall_w;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_series_value = rsp_value_ff;
   assign rsp_overflow     = rsp_overflow_ff;

endmodule

[rtl/lsc_checker.sv]
// ----------------------------------------------------------------------------
// Laguerre series evaluator port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "laguerre_series_clenshaw_eval_defines.svh"

module lsc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic signed [lsc_pkg::WORD_W-1:0]   req_coefficient,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [lsc_pkg::WORD_W-1:0]   rsp_series_value,
   input logic                                rsp_overflow,
   input logic                                csr_write_en,
   input logic [lsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input logic [lsc_pkg::WORD_W-1:0]          csr_data
);

   // A stalled result transaction holds its payload
   `LSC_ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_series_value) && $stable(rsp_overflow), "result changed while stalled")

   // After an accepted transaction the block stays busy through its prep cycles
   `LSC_ASSERT_CLK(a_busy_after_accept, req_valid && !req_stall |=> req_stall ##1 req_stall, "input accepted again too soon")

   // A new result only appears at the end of a busy step
   `LSC_ASSERT_CLK(a_result_from_step, $rose(rsp_valid) |-> $past(req_stall), "result appeared without a step in flight")

   // Reset leaves the block idle with no result pending
   `LSC_ASSERT_RST(a_reset_idle, reset |=> !rsp_valid && !req_stall, "block not idle after reset")

endmodule

bind laguerre_series_clenshaw_eval lsc_checker u_lsc_checker (.*);

[tb/sv/laguerre_series_clenshaw_eval_tb.sv]
// ----------------------------------------------------------------------------
// Laguerre series evaluator testbench
// Streams coefficients into the evaluator under random source gaps and sink
// stalls. Register settings change only between evaluations or partial
// evaluations. A scoreboard runs its own Clenshaw recurrence in Q32.32 and
// checks every returned series value and overflow flag in order.
// ----------------------------------------------------------------------------
module laguerre_series_clenshaw_eval_tb;

   localparam int WORD_W    = lsc_pkg::WORD_W;
   localparam int DEG_W     = lsc_pkg::DEG_W;
   localparam int CSR_IDX_W = lsc_pkg::CSR_IDX_W;

   localparam logic [WORD_W-1:0] WORD_MIN = lsc_pkg::WORD_MIN;
   localparam logic [WORD_W-1:0] WORD_MAX = lsc_pkg::WORD_MAX;

   localparam logic [CSR_IDX_W-1:0] CSR_EVAL_POINT    = lsc_pkg::CSR_EVAL_POINT;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_PARAM   = lsc_pkg::CSR_ALPHA_PARAM;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIES_DEGREE = lsc_pkg::CSR_SERIES_DEGREE;

   localparam int FRAC          = 32;
   localparam int MAX_DEG       = 255;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 1200000;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;
   localparam logic [WORD_W-1:0]    ONE_Q         = 64'h0000_0001_0000_0000;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              overflow;
   } series_result_type;

   // Recurrence state and the queue of series sums still to come back
   class series_scoreboard;
      logic [WORD_W-1:0] arg_x;
      logic [WORD_W-1:0] alpha;
      logic [DEG_W-1:0]  degree;
      int                k_now;
      logic [WORD_W-1:0] y1;
      logic [WORD_W-1:0] y2;
      logic              sat_flag;
      series_result_type expected_sums[$];
      int                error_count;

      function new();
         arg_x       = '0;
         alpha       = '0;
         degree      = '0;
         error_count = 0;
         restart();
      endfunction

      // Clear the recurrence and load the top index
      function void restart();
         k_now    = (degree > MAX_DEG) ? MAX_DEG : int'(degree);
         y1       = '0;
         y2       = '0;
         sat_flag = 1'b0;
      endfunction

      function void apply_write(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            CSR_EVAL_POINT:    arg_x = data;
            CSR_ALPHA_PARAM:   alpha = data;
            CSR_SERIES_DEGREE: begin
               degree = data[DEG_W-1:0];
               restart();
            end
            default: ;
         endcase
      endfunction

      function logic [WORD_W-1:0] clamp_add(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
         logic signed [WORD_W:0] s;
         s = $signed({a[WORD_W-1], a}) + $signed({b[WORD_W-1], b});
         if (s[WORD_W] != s[WORD_W-1]) begin
            sat_flag = 1'b1;
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
         end
         return s[WORD_W-1:0];
      endfunction

      function logic [WORD_W-1:0] clamp_sub(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
         logic signed [WORD_W:0] s;
         s = $signed({a[WORD_W-1], a}) - $signed({b[WORD_W-1], b});
         if (s[WORD_W] != s[WORD_W-1]) begin
            sat_flag = 1'b1;
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
         end
         return s[WORD_W-1:0];
      endfunction

      // Full product, round half up, drop the fraction, clamp to one word
      function logic [WORD_W-1:0] q_mul(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
         logic signed [2*WORD_W-1:0] p;
         p = $signed({{WORD_W{a[WORD_W-1]}}, a}) * $signed({{WORD_W{b[WORD_W-1]}}, b});
         p = p + (128'sd1 <<< (FRAC - 1));
         p = p >>> FRAC;
         if (p[2*WORD_W-1:WORD_W-1] != {(WORD_W+1){p[2*WORD_W-1]}}) begin
            sat_flag = 1'b1;
            return p[2*WORD_W-1] ? WORD_MIN : WORD_MAX;
         end
         return p[WORD_W-1:0];
      endfunction

      // Divide by a small integer, round to nearest with ties away from zero
      function logic [WORD_W-1:0] q_div(logic [WORD_W-1:0] v, int d);
         logic [WORD_W-1:0] dd;
         logic [WORD_W-1:0] mag;
         logic [WORD_W-1:0] q;
         dd  = 64'(d);
         mag = v[WORD_W-1] ? (~v + 64'd1) : v;
         q   = (mag + (dd >> 1)) / dd;
         return v[WORD_W-1] ? (~q + 64'd1) : q;
      endfunction

      // Advance the recurrence by one coefficient
      function void note_coefficient(logic [WORD_W-1:0] coef);
         logic [WORD_W-1:0] beta;
         logic [WORD_W-1:0] akp1;
         logic [WORD_W-1:0] q1;
         logic [WORD_W-1:0] q2;
         logic [WORD_W-1:0] y;
         beta = clamp_add(clamp_sub(alpha, arg_x), 64'(2 * k_now + 1) << FRAC);
         akp1 = clamp_add(alpha, 64'(k_now + 1) << FRAC);
         q1   = q_div(q_mul(beta, y1), k_now + 1);
         q2   = q_div(q_mul(akp1, y2), k_now + 2);
         y    = clamp_add(clamp_sub(q1, q2), coef);
         if (k_now == 0) begin
            expected_sums.push_back('{value: y, overflow: sat_flag});
            restart();
         end else begin
            y2    = y1;
            y1    = y;
            k_now = k_now - 1;
         end
      endfunction

      function void check_series(logic [WORD_W-1:0] value, logic ovf);
         series_result_type want;
         if (expected_sums.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected series result: value %h overflow %b", value, ovf);
            return;
         end
         want = expected_sums.pop_front();
         if (want.value !== value || want.overflow !== ovf) begin
            error_count++;
            if (error_count <= 10)
               $display("series mismatch: expected value %h overflow %b, got value %h overflow %b",
                        want.value, want.overflow, value, ovf);
         end
      endfunction

      function int outstanding();
         return expected_sums.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [WORD_W-1:0]   req_coefficient;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [WORD_W-1:0]   rsp_series_value;
   logic                       rsp_overflow;
   logic                       csr_write_en;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [WORD_W-1:0]          csr_data;

   series_scoreboard board;
   bit                idle_on;
   int                hold_left;
   int                cycle_count;

   laguerre_series_clenshaw_eval u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_coefficient  (req_coefficient),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_series_value (rsp_series_value),
      .rsp_overflow     (rsp_overflow),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("laguerre_series_clenshaw_eval regression: fail");
         $finish;
      end
   end

   // Stall the result side in short random bursts
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
         hold_left = $urandom_range(1, 4);
      end
      rsp_stall = (hold_left > 0);
   end

   // Check each result transaction as it leaves
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_series(rsp_series_value, rsp_overflow);
   end

   // Mostly narrow Q values, some full-width words and the two extremes
   function automatic logic [WORD_W-1:0] pick_word(input int narrow_bits);
      logic [WORD_W-1:0] w;
      int                pick;
      w    = {$urandom, $urandom};
      pick = $urandom_range(0, 11);
      if (pick == 0) return WORD_MAX;
      if (pick == 1) return WORD_MIN;
      if (pick <= 3) return w;
      return $signed(w << (WORD_W - narrow_bits)) >>> (WORD_W - narrow_bits);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_data     = data;
      @(posedge clock);
      board.apply_write(idx, data);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Degree write with junk in the unused upper bits
   task automatic write_degree(input int deg);
      logic [WORD_W-1:0] w;
      w            = {$urandom, $urandom};
      w[DEG_W-1:0] = DEG_W'(deg);
      write_reg(CSR_SERIES_DEGREE, w);
   endtask

   // Hold the payload until the block takes it
   task automatic send_coefficient(input logic [WORD_W-1:0] coef);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 2) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_coefficient = coef;
      do @(posedge clock); while (req_stall);
      board.note_coefficient(coef);
   endtask

   // Drop valid, wait for every pending sum, then let an unfinished
   // coefficient drain
   task automatic settle_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_directed();
      // degree zero after reset: each sum equals its coefficient
      send_coefficient('0);
      send_coefficient(WORD_MAX);
      send_coefficient(WORD_MIN);
      send_coefficient('1);
      // a write to the spare index changes nothing
      settle_block();
      write_reg(CSR_SPARE_IDX, '1);
      send_coefficient(ONE_Q);
      // plain evaluation with small values
      settle_block();
      write_reg(CSR_EVAL_POINT, ONE_Q);
      write_reg(CSR_ALPHA_PARAM, ONE_Q >> 1);
      write_reg(CSR_SERIES_DEGREE, 64'd2);
      send_coefficient(3 * ONE_Q);
      send_coefficient(-(2 * ONE_Q));
      send_coefficient(ONE_Q >> 2);
      // extreme arguments drive the adds and multiplies into saturation
      settle_block();
      write_reg(CSR_EVAL_POINT, WORD_MIN);
      write_reg(CSR_ALPHA_PARAM, WORD_MAX);
      write_reg(CSR_SERIES_DEGREE, 64'hFFFF_FFFF_FFFF_FF03);
      send_coefficient(WORD_MAX);
      send_coefficient(WORD_MAX);
      send_coefficient(WORD_MIN);
      send_coefficient(WORD_MAX);
      settle_block();
      write_reg(CSR_EVAL_POINT, WORD_MAX);
      write_reg(CSR_ALPHA_PARAM, WORD_MIN);
      write_reg(CSR_SERIES_DEGREE, 64'd1);
      send_coefficient(WORD_MIN);
      send_coefficient(WORD_MIN);
      // degree write in the middle of an evaluation restarts it
      settle_block();
      write_reg(CSR_EVAL_POINT, 3 * ONE_Q);
      write_reg(CSR_ALPHA_PARAM, '0);
      write_reg(CSR_SERIES_DEGREE, 64'd4);
      send_coefficient(ONE_Q);
      send_coefficient(-ONE_Q);
      settle_block();
      write_degree(1);
      send_coefficient(5 * ONE_Q);
      send_coefficient(ONE_Q >> 3);
      // argument and alpha change in the middle of an evaluation
      settle_block();
      write_reg(CSR_SERIES_DEGREE, 64'd2);
      send_coefficient(2 * ONE_Q);
      settle_block();
      write_reg(CSR_EVAL_POINT, -(ONE_Q >> 1));
      write_reg(CSR_ALPHA_PARAM, 2 * ONE_Q);
      send_coefficient(-(3 * ONE_Q));
      send_coefficient(ONE_Q);
   endtask

   task automatic run_random();
      int sent;
      int phase;
      int deg;
      int pick;
      int count;
      sent  = 0;
      phase = 0;
      deg   = 2;
      while (sent < RANDOM_ITEMS) begin
         settle_block();
         idle_on = (sent < RANDOM_ITEMS * 17 / 20) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1)) write_reg(CSR_EVAL_POINT, pick_word(37));
         if ($urandom_range(0, 1)) write_reg(CSR_ALPHA_PARAM, pick_word(37));
         if ($urandom_range(0, 7) == 0) write_reg(CSR_SPARE_IDX, {$urandom, $urandom});
         // mostly short series, now and then a long one, once the longest
         pick = $urandom_range(0, 59);
         if (phase == 3) begin
            deg = MAX_DEG;
         end else if (pick == 0) begin
            deg = $urandom_range(100, MAX_DEG);
         end else if (pick <= 8) begin
            deg = $urandom_range(9, 40);
         end else if ($urandom_range(0, 4) != 0) begin
            deg = $urandom_range(0, 8);
         end
         if (phase == 3 || $urandom_range(0, 4) != 0) write_degree(deg);
         count = (deg > 40) ? (deg + 1) : $urandom_range(1, 5) * (deg + 1);
         // leave an evaluation unfinished now and then
         if (deg > 0 && $urandom_range(0, 5) == 0) count += $urandom_range(1, deg);
         repeat (count) send_coefficient(pick_word(40));
         sent  += count;
         phase += 1;
      end
   endtask

   initial begin
      board           = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_coefficient = '0;
      rsp_stall       = 1'b0;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      idle_on         = 1'b1;
      hold_left       = 0;
      cycle_count     = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      run_random();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.error_count == 0 && board.outstanding() == 0)
         $display("laguerre_series_clenshaw_eval regression: pass");
      else
         $display("laguerre_series_clenshaw_eval regression: fail");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/lsc_pkg.sv
rtl/lsc_serial_mul.sv
rtl/lsc_serial_div.sv
rtl/laguerre_series_clenshaw_eval.sv
rtl/lsc_checker.sv
tb/sv/laguerre_series_clenshaw_eval_tb.sv
